// ----- rtl/mrg_pkg.sv -----
// ----------------------------------------------------------------------------
// mrg_pkg: shared constants and types of the middle MLFG random generator
// Lag length, LCG constants, operation codes, tap placement and the control
// word of the lag chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mrg_pkg;

	localparam int WORD_W      = 64;
	localparam int HALF_W      = WORD_W / 2;
	localparam int PROD_W      = 2 * WORD_W;

	localparam int LONG_LAG    = 15;
	localparam int SHORT_START = 12;
	localparam int LAG_IDX_W   = $clog2(LONG_LAG);

	// Cell 0 always holds the word at the long index; the short index trails it
	// by a fixed distance, so its word sits at a fixed cell as well.
	localparam int SHORT_TAP   = (LONG_LAG - 1) - (SHORT_START % LONG_LAG);

	localparam logic [WORD_W-1:0] LCG_MUL = 64'h3243_f6a8_885a_308d;
	localparam logic [WORD_W-1:0] LCG_ADD = 64'd1111111111111111111;
	localparam int                XSH     = 31;

	// Operation codes carried on op.
	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;

	// Chain moves: toward cell 0 after a draw, toward the tail while seeding.
	typedef struct packed {
		logic shl;
		logic shr;
	} chain_ctl_t;

endpackage : mrg_pkg

`default_nettype wire

// ----- rtl/middle_mlfg_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// middle_mlfg_random_generator_unit: middle-product multiplicative lagged
// Fibonacci generator
// Fifteen 64-bit lag words in a row of cells; a draw multiplies two of them and
// returns bits 95..32 of the product, a reseed refills the row from an LCG.
// ----------------------------------------------------------------------------
//
//   channel | ports                               | carries
//   --------+-------------------------------------+-------------------------------
//   in      | in_valid, in_stall, op, seed_value  | op 0 draw, op 1 reseed
//   out     | out_valid, out_stall, random_word   | one word per draw, none per seed
//
// A draw runs four 32x32 partial products through the single multiplier in
// mrg_mul, one add each, then the write back to the result register. A
// reseed runs 15 LCG steps, all through the same multiplier. After reset the
// unit runs a reseed with seed 0 and holds in_stall high until it is done. A
// result waiting on out_stall does not block the next accept; a draw finished
// behind it holds until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module middle_mlfg_random_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [63:0] seed_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] random_word
);

	typedef enum logic [4:0] {
		ST_BOOT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_DRAW = 5'b00100,
		ST_PUT  = 5'b01000,
		ST_SEED = 5'b10000
	} state_t;

	localparam logic [mrg_pkg::LAG_IDX_W-1:0] LAST_SEED =
		mrg_pkg::LAG_IDX_W'(mrg_pkg::LONG_LAG - 1);

	state_t                          state_q, state_d;
	logic [mrg_pkg::LAG_IDX_W-1:0]   cnt_q, cnt_d;
	logic                            out_valid_q;
	logic [mrg_pkg::WORD_W-1:0]      out_word_q;
	logic                            load_out;

	mrg_pkg::chain_ctl_t             ctl;
	logic [mrg_pkg::WORD_W-1:0]      tap_long, tap_short;

	logic                            mul_start;
	logic [mrg_pkg::WORD_W-1:0]      mul_a, mul_b;
	logic                            mul_done;
	logic [mrg_pkg::PROD_W-1:0]      mul_product;

	logic [mrg_pkg::WORD_W-1:0]      lcg_next;
	logic [mrg_pkg::WORD_W-1:0]      seed_word;

	// LCG step and the tempering of the stored word
	assign lcg_next  = mul_product[mrg_pkg::WORD_W-1:0] + mrg_pkg::LCG_ADD;
	assign seed_word = (lcg_next ^ (lcg_next >> mrg_pkg::XSH)) | 64'd1;

	mrg_chain u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.fill_tail (mul_product[mrg_pkg::WORD_W-1:0]),
		.fill_head (seed_word),
		.tap_long  (tap_long),
		.tap_short (tap_short)
	);

	mrg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_product)
	);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		mul_start = 1'b0;
		mul_a     = tap_long;
		mul_b     = tap_short;
		ctl       = '0;
		load_out  = 1'b0;
		case (state_q)
			ST_BOOT: begin
				// seed with zero out of reset
				mul_start = 1'b1;
				mul_a     = '0;
				mul_b     = mrg_pkg::LCG_MUL;
				cnt_d     = '0;
				state_d   = ST_SEED;
			end
			ST_IDLE: begin
				if (in_valid) begin
					mul_start = 1'b1;
					if (op == mrg_pkg::OP_RESEED) begin
						mul_a   = seed_value;
						mul_b   = mrg_pkg::LCG_MUL;
						cnt_d   = '0;
						state_d = ST_SEED;
					end else begin
						state_d = ST_DRAW;
					end
				end
			end
			ST_DRAW: begin
				if (mul_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				// hold the product until the output register frees, then write
				// the low half back at the tail and advance the row
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					ctl.shl  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SEED: begin
				if (mul_done) begin
					ctl.shr = 1'b1;
					if (cnt_q == LAST_SEED) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d     = cnt_q + 1'b1;
						mul_start = 1'b1;
						mul_a     = lcg_next;
						mul_b     = mrg_pkg::LCG_MUL;
					end
				end
			end
			default: begin
				state_d = ST_BOOT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q <= mul_product[mrg_pkg::WORD_W+mrg_pkg::HALF_W-1:mrg_pkg::HALF_W];
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

endmodule : middle_mlfg_random_generator_unit

`default_nettype wire

// ----- rtl/mrg_cell.sv -----
// ----------------------------------------------------------------------------
// mrg_cell: one lag word of the generator
// Holds one 64-bit word and takes the word of either neighbor on a move.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_cell (
	input  wire logic                       clk,
	input  wire mrg_pkg::chain_ctl_t        ctl,
	input  wire logic [mrg_pkg::WORD_W-1:0] from_next,
	input  wire logic [mrg_pkg::WORD_W-1:0] from_prev,
	output logic      [mrg_pkg::WORD_W-1:0] word
);

	logic [mrg_pkg::WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.shl) begin
			word_q <= from_next;
		end else if (ctl.shr) begin
			word_q <= from_prev;
		end
	end

	assign word = word_q;

endmodule : mrg_cell

`default_nettype wire

// ----- rtl/mrg_chain.sv -----
// ----------------------------------------------------------------------------
// mrg_chain: row of lag cells
// Cell i holds the word i places below the long index. Taps sit at cell 0
// (long lag) and at the short tap.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_chain (
	input  wire logic                       clk,
	input  wire mrg_pkg::chain_ctl_t        ctl,
	input  wire logic [mrg_pkg::WORD_W-1:0] fill_tail,
	input  wire logic [mrg_pkg::WORD_W-1:0] fill_head,
	output logic      [mrg_pkg::WORD_W-1:0] tap_long,
	output logic      [mrg_pkg::WORD_W-1:0] tap_short
);

	logic [mrg_pkg::WORD_W-1:0] words [mrg_pkg::LONG_LAG];

	for (genvar i = 0; i < mrg_pkg::LONG_LAG; i++) begin : g_cell
		logic [mrg_pkg::WORD_W-1:0] nxt;
		logic [mrg_pkg::WORD_W-1:0] prv;

		if (i == mrg_pkg::LONG_LAG - 1) begin : g_tail
			assign nxt = fill_tail;
		end else begin : g_mid_n
			assign nxt = words[i+1];
		end

		if (i == 0) begin : g_head
			assign prv = fill_head;
		end else begin : g_mid_p
			assign prv = words[i-1];
		end

		mrg_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_next (nxt),
			.from_prev (prv),
			.word      (words[i])
		);
	end

	assign tap_long  = words[0];
	assign tap_short = words[mrg_pkg::SHORT_TAP];

endmodule : mrg_chain

`default_nettype wire

// ----- rtl/mrg_mul.sv -----
// ----------------------------------------------------------------------------
// mrg_mul: sequential 64x64 multiplier
// One 32x32 partial product per cycle, registered, then added into a 128-bit
// accumulator. Done pulses in the cycle the full product first shows.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [mrg_pkg::WORD_W-1:0] a,
	input  wire logic [mrg_pkg::WORD_W-1:0] b,
	output logic                            done,
	output logic      [mrg_pkg::PROD_W-1:0] product
);

	localparam logic [1:0] LAST_STEP = 2'd3;

	logic [mrg_pkg::WORD_W-1:0]   a_q, b_q;
	logic [mrg_pkg::PROD_W-1:0]   acc_q;
	logic                         issue_q;
	logic [1:0]                   idx_q;
	logic [mrg_pkg::WORD_W-1:0]   p_s1;
	logic [1:0]                   idx_s1;
	logic                         v_s1;
	logic                         done_q;
	logic [mrg_pkg::HALF_W-1:0]   a_half, b_half;
	logic [mrg_pkg::PROD_W-1:0]   term;

	assign a_half = idx_q[0] ? a_q[mrg_pkg::WORD_W-1:mrg_pkg::HALF_W]
	                         : a_q[mrg_pkg::HALF_W-1:0];
	assign b_half = idx_q[1] ? b_q[mrg_pkg::WORD_W-1:mrg_pkg::HALF_W]
	                         : b_q[mrg_pkg::HALF_W-1:0];

	// place the partial product by the halves it came from
	always_comb begin
		case (idx_s1)
			2'd0:    term = {{mrg_pkg::WORD_W{1'b0}}, p_s1};
			2'd3:    term = {p_s1, {mrg_pkg::WORD_W{1'b0}}};
			default: term = {{mrg_pkg::HALF_W{1'b0}}, p_s1, {mrg_pkg::HALF_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= v_s1 && (idx_s1 == LAST_STEP);
			v_s1   <= issue_q;
			if (start) begin
				issue_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == LAST_STEP) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		p_s1   <= {{mrg_pkg::HALF_W{1'b0}}, a_half} * {{mrg_pkg::HALF_W{1'b0}}, b_half};
		idx_s1 <= idx_q;
		if (start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + term;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule : mrg_mul

`default_nettype wire

// ----- rtl/mrg_checker.sv -----
// ----------------------------------------------------------------------------
// mrg_checker: port-level checks of the generator
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mrg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        op,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] random_word
);

	// a stalled result word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(random_word))
		else $error("result word changed while stalled");

	// one word at a time: an accept closes the input for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on two cycles in a row");

	// a reseed produces no result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == mrg_pkg::OP_RESEED) && !out_valid |=> !out_valid)
		else $error("result appeared after a reseed");

	// a result only appears after a draw has been running
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a draw in flight");

endmodule : mrg_checker

bind middle_mlfg_random_generator_unit mrg_checker u_mrg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.op          (op),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.random_word (random_word)
);

`default_nettype wire
